// ===== hw/rtl/slbs_pkg.sv =====
package slbs_pkg;

    localparam int unsigned MODE_W   = 2;
    localparam int unsigned CODE_W   = 4;
    localparam int unsigned PULSE_W  = 2;
    localparam int unsigned TIMER_W  = 9;
    localparam int unsigned S_DATA_W = 8;
    localparam int unsigned S_USER_W = 8;
    localparam int unsigned M_DATA_W = 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_EVENT  = 2'd0,
        MODE_TICK   = 2'd1,
        MODE_SLEEP  = 2'd2,
        MODE_ENABLE = 2'd3
    } mode_t;

    localparam logic [CODE_W-1:0] CODE_BOOT      = 4'd0;
    localparam logic [CODE_W-1:0] CODE_ACTIVE    = 4'd1;
    localparam logic [CODE_W-1:0] CODE_CAPTURE   = 4'd2;
    localparam logic [CODE_W-1:0] CODE_RECORDING = 4'd3;
    localparam logic [CODE_W-1:0] CODE_INFER     = 4'd4;
    localparam logic [CODE_W-1:0] CODE_UPLINK    = 4'd5;
    localparam logic [CODE_W-1:0] CODE_GPS_WAIT  = 4'd6;
    localparam logic [CODE_W-1:0] CODE_LINK_OK   = 4'd7;

    typedef struct packed {
        mode_t             mode;
        logic [CODE_W-1:0] event_code;
        logic              enable_value;
    } item_t;

    typedef struct packed {
        logic asleep;
        logic busy_res;
        logic led_level;
    } result_t;

    typedef struct packed {
        logic [PULSE_W-1:0] count;
        logic [TIMER_W-1:0] on_ms;
        logic [TIMER_W-1:0] off_ms;
    } pattern_t;

    function automatic pattern_t blink_pattern(input logic [CODE_W-1:0] code);
        pattern_t p;
        case (code)
            CODE_BOOT:      p = '{count: 2'd1, on_ms: 9'd120, off_ms: 9'd80};
            CODE_ACTIVE:    p = '{count: 2'd1, on_ms: 9'd40,  off_ms: 9'd40};
            CODE_CAPTURE:   p = '{count: 2'd1, on_ms: 9'd60,  off_ms: 9'd40};
            CODE_RECORDING: p = '{count: 2'd1, on_ms: 9'd300, off_ms: 9'd80};
            CODE_INFER:     p = '{count: 2'd1, on_ms: 9'd80,  off_ms: 9'd60};
            CODE_UPLINK:    p = '{count: 2'd2, on_ms: 9'd70,  off_ms: 9'd90};
            CODE_GPS_WAIT:  p = '{count: 2'd2, on_ms: 9'd120, off_ms: 9'd180};
            CODE_LINK_OK:   p = '{count: 2'd2, on_ms: 9'd50,  off_ms: 9'd70};
            default:        p = '{count: 2'd3, on_ms: 9'd50,  off_ms: 9'd70};
        endcase
        return p;
    endfunction

endpackage

// ===== hw/rtl/slbs_core.sv =====
module slbs_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  slbs_pkg::item_t  item,
    output slbs_pkg::result_t result
);
    import slbs_pkg::*;

    logic               lit_reg, lit_next;
    logic [PULSE_W-1:0] pulses_reg, pulses_next;
    logic [TIMER_W-1:0] count_reg, count_next;
    logic [TIMER_W-1:0] on_reg, on_next;
    logic [TIMER_W-1:0] off_reg, off_next;
    logic               enabled_reg, enabled_next;
    logic               sleeping_reg, sleeping_next;

    pattern_t           pat;
    logic [TIMER_W-1:0] count_dec;
    logic [PULSE_W-1:0] pulses_dec;
    logic               wake;

    assign pat        = blink_pattern(item.event_code);
    assign count_dec  = count_reg - 1'b1;
    assign pulses_dec = (pulses_reg != '0) ? pulses_reg - 1'b1 : '0;
    assign wake       = (item.event_code == CODE_BOOT) || (item.event_code == CODE_ACTIVE);

    always_comb begin
        lit_next      = lit_reg;
        pulses_next   = pulses_reg;
        count_next    = count_reg;
        on_next       = on_reg;
        off_next      = off_reg;
        enabled_next  = enabled_reg;
        sleeping_next = sleeping_reg;
        case (item.mode)
            MODE_EVENT: begin
                if (enabled_reg) begin
                    if (wake) begin
                        sleeping_next = 1'b0;
                    end
                    if (wake || !sleeping_reg) begin
                        lit_next    = 1'b1;
                        pulses_next = pat.count;
                        on_next     = pat.on_ms;
                        off_next    = pat.off_ms;
                        count_next  = pat.on_ms;
                    end
                end
            end
            MODE_TICK: begin
                if (count_reg != '0) begin
                    count_next = count_dec;
                    if (count_dec == '0) begin
                        if (!enabled_reg || sleeping_reg) begin
                            lit_next    = 1'b0;
                            pulses_next = '0;
                        end else if (lit_reg) begin
                            lit_next    = 1'b0;
                            pulses_next = pulses_dec;
                            if (pulses_dec != '0) begin
                                count_next = off_reg;
                            end
                        end else if (pulses_reg != '0) begin
                            lit_next   = 1'b1;
                            count_next = on_reg;
                        end
                    end
                end
            end
            MODE_SLEEP: begin
                sleeping_next = 1'b1;
                lit_next      = 1'b0;
                pulses_next   = '0;
                count_next    = '0;
            end
            MODE_ENABLE: begin
                enabled_next = item.enable_value;
                if (!item.enable_value) begin
                    lit_next    = 1'b0;
                    pulses_next = '0;
                    count_next  = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        result.led_level = lit_next;
        result.busy_res  = (count_next != '0);
        result.asleep    = sleeping_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lit_reg      <= 1'b0;
            pulses_reg   <= '0;
            count_reg    <= '0;
            on_reg       <= '0;
            off_reg      <= '0;
            enabled_reg  <= 1'b1;
            sleeping_reg <= 1'b0;
        end else if (advance) begin
            lit_reg      <= lit_next;
            pulses_reg   <= pulses_next;
            count_reg    <= count_next;
            on_reg       <= on_next;
            off_reg      <= off_next;
            enabled_reg  <= enabled_next;
            sleeping_reg <= sleeping_next;
        end
    end

    a_timer_only_when_awake: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != '0) |-> (enabled_reg && !sleeping_reg))
        else $error("phase timer running while disabled or asleep");

    a_lit_has_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        lit_reg |-> (count_reg != '0))
        else $error("led lit with idle phase timer");

    a_no_pulses_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (pulses_reg == '0) |-> (!lit_reg && (count_reg == '0)))
        else $error("sequence active with no pulses left");

endmodule

// ===== hw/rtl/status_led_blink_sequencer.sv =====
// Status LED blink-code sequencer. Each input beat carries a kind in s_tuser (event, 1 ms tick,
// prepare sleep, set enable) and one result beat comes out per input beat, giving the LED
// level, whether a phase timer is running, and the sleeping flag after that beat. The block
// takes one beat per clock while m_tready is high: a beat is registered at the input, the flag
// and counter update runs in one short combinational step, and the result lands in an output
// register. The block is ready right after reset, enabled and awake, with the LED off.
module status_led_blink_sequencer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [slbs_pkg::S_DATA_W-1:0] s_tdata,  // event_code[3:0], enable_value[4]
    input  logic [slbs_pkg::S_USER_W-1:0] s_tuser,  // mode[1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [slbs_pkg::M_DATA_W-1:0] m_tdata   // led_level[0], busy_res[1], asleep[2]
);
    import slbs_pkg::*;

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    result_t core_res;
    logic    advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.mode         <= mode_t'(s_tuser[MODE_W-1:0]);
            in_item_reg.event_code   <= s_tdata[CODE_W-1:0];
            in_item_reg.enable_value <= s_tdata[CODE_W];
        end
    end

    slbs_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_item_reg),
        .result  (core_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - $bits(result_t)){1'b0}}, out_res_reg};

endmodule

// ===== sim/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import slbs_pkg::*;

    localparam int ITEMS_TARGET = 550;
    localparam int QUIET_TAIL   = 80;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 10;
    localparam int PLAN_LEN     = 25;

    localparam logic [CODE_W-1:0] CODE_ERR_LO = 4'd8;
    localparam logic [CODE_W-1:0] CODE_ERR_HI = 4'd15;

    typedef struct packed {
        mode_t             mode;
        logic [CODE_W-1:0] code;
        logic              en;
        logic              pinned;
        logic              exp_led;
        logic              exp_busy;
        logic              exp_asleep;
    } plan_row_t;

    logic                aclk;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [S_USER_W-1:0] s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    // blink state as seen by the predictor
    logic               lit_q      = 1'b0;
    logic [PULSE_W-1:0] pulses_q   = '0;
    logic [TIMER_W-1:0] countdown_q = '0;
    logic [TIMER_W-1:0] on_q       = '0;
    logic [TIMER_W-1:0] off_q      = '0;
    logic               enabled_q  = 1'b1;
    logic               sleeping_q = 1'b0;

    result_t led_expected [$];

    int  errors        = 0;
    int  beats_sent    = 0;
    int  results_seen  = 0;
    int  cycles        = 0;
    int  patterns_done = 0;
    int  mode_count [4] = '{0, 0, 0, 0};
    int  gap_pct       = 0;
    int  stall_pct     = 0;
    bit  quiet         = 1'b0;

    plan_row_t directed_plan [PLAN_LEN] = '{
        '{MODE_TICK,   CODE_BOOT,      1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
        '{MODE_EVENT,  CODE_BOOT,      1'b0, 1'b1, 1'b1, 1'b1, 1'b0},
        '{MODE_TICK,   CODE_ERR_HI,    1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{MODE_EVENT,  CODE_ERR_HI,    1'b0, 1'b1, 1'b1, 1'b1, 1'b0},
        '{MODE_ENABLE, CODE_BOOT,      1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
        '{MODE_EVENT,  CODE_ACTIVE,    1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
        '{MODE_TICK,   CODE_BOOT,      1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
        '{MODE_ENABLE, CODE_BOOT,      1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
        '{MODE_EVENT,  CODE_CAPTURE,   1'b0, 1'b1, 1'b1, 1'b1, 1'b0},
        '{MODE_ENABLE, CODE_BOOT,      1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{MODE_SLEEP,  CODE_BOOT,      1'b0, 1'b1, 1'b0, 1'b0, 1'b1},
        '{MODE_EVENT,  CODE_RECORDING, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1},
        '{MODE_ENABLE, CODE_BOOT,      1'b1, 1'b1, 1'b0, 1'b0, 1'b1},
        '{MODE_EVENT,  CODE_ACTIVE,    1'b0, 1'b1, 1'b1, 1'b1, 1'b0},
        '{MODE_SLEEP,  CODE_BOOT,      1'b0, 1'b1, 1'b0, 1'b0, 1'b1},
        '{MODE_ENABLE, CODE_BOOT,      1'b0, 1'b1, 1'b0, 1'b0, 1'b1},
        '{MODE_SLEEP,  CODE_BOOT,      1'b0, 1'b1, 1'b0, 1'b0, 1'b1},
        '{MODE_EVENT,  CODE_BOOT,      1'b0, 1'b1, 1'b0, 1'b0, 1'b1},
        '{MODE_ENABLE, CODE_BOOT,      1'b1, 1'b1, 1'b0, 1'b0, 1'b1},
        '{MODE_EVENT,  CODE_BOOT,      1'b0, 1'b1, 1'b1, 1'b1, 1'b0},
        '{MODE_EVENT,  CODE_INFER,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{MODE_EVENT,  CODE_UPLINK,    1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{MODE_EVENT,  CODE_GPS_WAIT,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{MODE_EVENT,  CODE_LINK_OK,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{MODE_EVENT,  CODE_ERR_LO,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0}
    };

    status_led_blink_sequencer DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic item_t make_item(input logic [1:0] mode, input logic [CODE_W-1:0] code,
                                        input logic en);
        item_t it;
        it.mode         = mode_t'(mode);
        it.event_code   = code;
        it.enable_value = en;
        return it;
    endfunction

    function automatic result_t blink_step(input item_t it);
        result_t r;
        case (it.mode)
            MODE_EVENT: begin
                if (enabled_q) begin
                    if (it.event_code == CODE_BOOT || it.event_code == CODE_ACTIVE) begin
                        sleeping_q = 1'b0;
                    end
                    if (!sleeping_q) begin
                        case (it.event_code)
                            CODE_BOOT:      {pulses_q, on_q, off_q} = {2'd1, 9'd120, 9'd80};
                            CODE_ACTIVE:    {pulses_q, on_q, off_q} = {2'd1, 9'd40, 9'd40};
                            CODE_CAPTURE:   {pulses_q, on_q, off_q} = {2'd1, 9'd60, 9'd40};
                            CODE_RECORDING: {pulses_q, on_q, off_q} = {2'd1, 9'd300, 9'd80};
                            CODE_INFER:     {pulses_q, on_q, off_q} = {2'd1, 9'd80, 9'd60};
                            CODE_UPLINK:    {pulses_q, on_q, off_q} = {2'd2, 9'd70, 9'd90};
                            CODE_GPS_WAIT:  {pulses_q, on_q, off_q} = {2'd2, 9'd120, 9'd180};
                            CODE_LINK_OK:   {pulses_q, on_q, off_q} = {2'd2, 9'd50, 9'd70};
                            default:        {pulses_q, on_q, off_q} = {2'd3, 9'd50, 9'd70};
                        endcase
                        lit_q       = 1'b1;
                        countdown_q = on_q;
                    end
                end
            end
            MODE_TICK: begin
                if (countdown_q != 0) begin
                    countdown_q = countdown_q - 1'b1;
                    if (countdown_q == 0) begin
                        if (!enabled_q || sleeping_q) begin
                            {lit_q, pulses_q} = '0;
                        end else if (lit_q) begin
                            lit_q = 1'b0;
                            if (pulses_q != 0) pulses_q = pulses_q - 1'b1;
                            if (pulses_q != 0) begin
                                countdown_q = off_q;
                            end else begin
                                patterns_done++;
                            end
                        end else if (pulses_q != 0) begin
                            lit_q       = 1'b1;
                            countdown_q = on_q;
                        end
                    end
                end
            end
            MODE_SLEEP: begin
                sleeping_q = 1'b1;
                {lit_q, pulses_q, countdown_q} = '0;
            end
            default: begin
                enabled_q = it.enable_value;
                if (!enabled_q) {lit_q, pulses_q, countdown_q} = '0;
            end
        endcase
        r.led_level = lit_q;
        r.busy_res  = (countdown_q != 0);
        r.asleep    = sleeping_q;
        return r;
    endfunction

    task automatic send_beat(input item_t it, input logic pinned, input result_t pinned_res);
        result_t model_res;
        logic [S_DATA_W-1:0] data_word;
        logic [S_USER_W-1:0] user_word;
        if (beats_sent % 48 == 0) begin
            case ($urandom_range(0, 2))
                0: gap_pct = 0;
                1: gap_pct = 15;
                default: gap_pct = 40;
            endcase
            case ($urandom_range(0, 2))
                0: stall_pct = 0;
                1: stall_pct = 15;
                default: stall_pct = 40;
            endcase
        end
        if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        data_word = '0;
        data_word[CODE_W-1:0] = it.event_code;
        data_word[CODE_W]     = it.enable_value;
        user_word = '0;
        user_word[MODE_W-1:0] = it.mode;
        s_tvalid <= 1'b1;
        s_tdata  <= data_word;
        s_tuser  <= user_word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        model_res = blink_step(it);
        led_expected.push_back(pinned ? pinned_res : model_res);
        mode_count[it.mode]++;
        beats_sent++;
        if (beats_sent >= ITEMS_TARGET + PLAN_LEN - QUIET_TAIL) quiet = 1'b1;
    endtask

    task automatic send_ticks(input int run);
        repeat (run) begin
            if (beats_sent < ITEMS_TARGET + PLAN_LEN) begin
                send_beat(make_item(MODE_TICK, CODE_W'($urandom), 1'($urandom)), 1'b0, '0);
            end
        end
    endtask

    // receiver back-pressure
    initial begin
        forever begin
            if (!quiet && $urandom_range(0, 99) < stall_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[2:0]);
            results_seen++;
            if (led_expected.size() == 0) begin
                $display("%0t: unexpected result beat, got %b", $time, got);
                errors++;
            end else begin
                want = led_expected.pop_front();
                if (got.led_level !== want.led_level) begin
                    $display("%0t: led_level expected %b actual %b", $time,
                             want.led_level, got.led_level);
                    errors++;
                end
                if (got.busy_res !== want.busy_res) begin
                    $display("%0t: busy_res expected %b actual %b", $time,
                             want.busy_res, got.busy_res);
                    errors++;
                end
                if (got.asleep !== want.asleep) begin
                    $display("%0t: asleep expected %b actual %b", $time,
                             want.asleep, got.asleep);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, led_expected.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        plan_row_t row;
        result_t   pin_res;
        int        pick;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < PLAN_LEN; i++) begin
            row = directed_plan[i];
            pin_res.led_level = row.exp_led;
            pin_res.busy_res  = row.exp_busy;
            pin_res.asleep    = row.exp_asleep;
            send_beat(make_item(row.mode, row.code, row.en), row.pinned, pin_res);
        end

        // mostly an event followed by a run of ticks, long enough at times to finish a pattern
        while (beats_sent < ITEMS_TARGET + PLAN_LEN) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                send_beat(make_item(MODE_EVENT, CODE_W'($urandom_range(0, 15)), 1'($urandom)),
                          1'b0, '0);
                send_ticks(($urandom_range(0, 2) == 0) ? $urandom_range(150, 320)
                                                       : $urandom_range(1, 90));
            end else if (pick < 65) begin
                send_ticks($urandom_range(1, 20));
            end else if (pick < 73) begin
                send_beat(make_item(MODE_SLEEP, CODE_W'($urandom), 1'($urandom)), 1'b0, '0);
            end else if (pick < 88) begin
                send_beat(make_item(MODE_ENABLE, CODE_W'($urandom), $urandom_range(0, 3) != 0),
                          1'b0, '0);
            end else begin
                send_beat(make_item(MODE_W'($urandom), CODE_W'($urandom), 1'($urandom)),
                          1'b0, '0);
            end
        end
        s_tvalid <= 1'b0;

        while (led_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("ran %0d beats: %0d events, %0d ticks, %0d sleeps, %0d enable writes",
                 beats_sent, mode_count[MODE_EVENT], mode_count[MODE_TICK],
                 mode_count[MODE_SLEEP], mode_count[MODE_ENABLE]);
        $display("%0d results checked, %0d blink patterns played to the end",
                 results_seen, patterns_done);
        if (errors == 0 && led_expected.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
